@@ rtl/lsd_pkg.sv @@
// Package for the lidar scan deframer: field widths, codes, controller states
// and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package lsd_pkg;

    // Field widths of the stream words
    localparam int QUAL_W  = 8;
    localparam int ANGLE_W = 15;
    localparam int DIST_W  = 16;
    localparam int IDX_W   = 6;
    localparam int COUNT_W = 16;
    localparam int BYTE_W  = 8;
    localparam int TDATA_W = 64;

    // Input kinds carried in s_tuser
    localparam logic CMD_ARM  = 1'b0;
    localparam logic CMD_DATA = 1'b1;

    // Configuration register indexes
    localparam logic REG_SCAN_MODE = 1'b0;
    localparam logic REG_PACKETS   = 1'b1;

    localparam logic MODE_EXPRESS = 1'b1;

    // Express sync nibbles, packets reset value and count limit
    localparam logic [3:0] SYNC1_NIB   = 4'hA;
    localparam logic [3:0] SYNC2_NIB   = 4'h5;
    localparam logic [7:0] PPS_RESET   = 8'd79;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    // Result kinds carried in m_tuser
    typedef enum logic [1:0] {
        EV_POINT = 2'd0,
        EV_CABIN = 2'd1,
        EV_DONE  = 2'd2,
        EV_ERROR = 2'd3
    } event_t;

    // What the datapath does with the held input word
    typedef enum logic [2:0] {
        OP_NONE,
        OP_DROP,
        OP_ARM,
        OP_STD,
        OP_SYNC1,
        OP_SYNC2,
        OP_PAY
    } byte_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STD,
        ST_SYNC1,
        ST_SYNC2,
        ST_PAYLOAD,
        ST_DRAIN_RD,
        ST_DRAIN_OUT,
        ST_DONE_OUT
    } ctrl_state_t;

    typedef struct packed {
        byte_op_t op;
        logic     cnt_inc;
        logic     out_load;
        event_t   out_sel;
        logic     out_last;
        logic     drain_start;
        logic     drain_rd;
        logic     drain_next;
    } dp_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic in_cmd;
        logic out_free;
        logic scan_mode;
        logic std_full;
        logic std_start;
        logic std_check;
        logic frame_started;
        logic cnt_gt1;
        logic sync1_ok;
        logic sync2_ok;
        logic pay_final;
        logic xor_match;
        logic drain_last;
        logic target_hit;
    } dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/lsd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lsd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 40,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/lsd_dp.sv @@
// Datapath of the lidar scan deframer: input hold word, record and packet
// registers, cabin RAM, counters and the output register.
// Depends on lsd_pkg and lsd_ram.
`default_nettype none

module lsd_dp
    import lsd_pkg::*;
#(
    parameter int CABINS = 40
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // input stream
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [BYTE_W-1:0]  s_tdata,
    input  wire logic               s_tuser,
    // result stream
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,
    output logic [1:0]              m_tuser,
    output logic                    m_tlast,
    // configuration
    input  wire logic               cfg_valid,
    input  wire logic               cfg_index,
    input  wire logic [7:0]         cfg_data,
    // controller link
    input  wire dp_cmd_t            cmd,
    output dp_stat_t                stat
);

    localparam int AW        = (CABINS > 1) ? $clog2(CABINS) : 1;
    localparam int PAY_TOTAL = 2 + 2 * CABINS;
    localparam int POS_W     = $clog2(PAY_TOTAL);

    // Configuration registers
    logic       scan_mode_reg;
    logic [7:0] pps_reg;

    // Input hold word
    logic              in_valid_reg;
    logic              in_cmd_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              take;

    // Scan state
    logic [2:0]         std_pos_reg;
    logic [7:0]         rec_reg [4];
    logic               frame_started_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [7:0]         pending_reg;
    logic [7:0]         exp_reg;
    logic [7:0]         xor_reg;
    logic [ANGLE_W-1:0] angle_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [AW-1:0]      drain_idx_reg;

    // RAM
    logic             ram_we;
    logic [POS_W-1:0] pos_off;
    logic [AW-1:0]    ram_waddr;
    logic [DIST_W-1:0] ram_rdata;

    // Output register
    logic               out_valid_reg;
    event_t             out_ev_reg;
    logic               out_last_reg;
    logic [QUAL_W-1:0]  out_q_reg;
    logic [ANGLE_W-1:0] out_ang_reg;
    logic [DIST_W-1:0]  out_dist_reg;
    logic [IDX_W-1:0]   out_idx_reg;
    logic [COUNT_W-1:0] out_cnt_reg;
    logic [7:0]         target;

    assign take     = (cmd.op != OP_NONE);
    assign s_tready = !in_valid_reg || take;

    // Hold one input word so a new one can enter while a result waits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (take) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg  <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_mode_reg <= 1'b0;
            pps_reg       <= PPS_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == REG_SCAN_MODE) begin
                scan_mode_reg <= cfg_data[0];
            end else begin
                pps_reg <= cfg_data;
            end
        end
    end

    // Saturating item count
    always_comb begin
        count_next = count_reg;
        if (cmd.cnt_inc && count_reg != COUNT_MAX) begin
            count_next = count_reg + COUNT_W'(1);
        end
    end

    // Scan state update per consumed word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            std_pos_reg       <= '0;
            frame_started_reg <= 1'b0;
            pos_reg           <= '0;
            pending_reg       <= '0;
            exp_reg           <= '0;
            xor_reg           <= '0;
            angle_reg         <= '0;
            count_reg         <= '0;
            drain_idx_reg     <= '0;
            for (int i = 0; i < 4; i++) begin
                rec_reg[i] <= '0;
            end
        end else begin
            // Clear the count on arm, else advance it
            if (cmd.op == OP_ARM) begin
                count_reg <= '0;
            end else begin
                count_reg <= count_next;
            end
            case (cmd.op)
                OP_ARM: begin
                    std_pos_reg       <= '0;
                    frame_started_reg <= 1'b0;
                    pos_reg           <= '0;
                    pending_reg       <= '0;
                    exp_reg           <= '0;
                    xor_reg           <= '0;
                    angle_reg         <= '0;
                end
                OP_STD: begin
                    if (!stat.std_full) begin
                        rec_reg[std_pos_reg[1:0]] <= in_byte_reg;
                        std_pos_reg <= std_pos_reg + 3'd1;
                    end else begin
                        std_pos_reg <= '0;
                        if (stat.std_start && !frame_started_reg && stat.std_check) begin
                            frame_started_reg <= 1'b1;
                        end
                    end
                end
                OP_SYNC1: begin
                    if (stat.sync1_ok) begin
                        exp_reg <= {4'h0, in_byte_reg[3:0]};
                    end
                end
                OP_SYNC2: begin
                    if (stat.sync2_ok) begin
                        exp_reg   <= {in_byte_reg[3:0], exp_reg[3:0]};
                        xor_reg   <= '0;
                        pos_reg   <= '0;
                        angle_reg <= '0;
                    end
                end
                OP_PAY: begin
                    xor_reg <= xor_reg ^ in_byte_reg;
                    if (pos_reg == POS_W'(0)) begin
                        angle_reg[7:0] <= in_byte_reg;
                    end else if (pos_reg == POS_W'(1)) begin
                        angle_reg[ANGLE_W-1:8] <= in_byte_reg[ANGLE_W-9:0];
                    end else if (!pos_reg[0]) begin
                        pending_reg <= in_byte_reg;
                    end
                    if (stat.pay_final) begin
                        pos_reg <= '0;
                    end else begin
                        pos_reg <= pos_reg + POS_W'(1);
                    end
                end
                default: begin
                end
            endcase
            // Walk the cabin store
            if (cmd.drain_start) begin
                drain_idx_reg <= '0;
            end else if (cmd.drain_next) begin
                drain_idx_reg <= drain_idx_reg + AW'(1);
            end
        end
    end

    // Store a cabin on its high byte
    assign pos_off   = pos_reg - POS_W'(2);
    assign ram_waddr = AW'(pos_off >> 1);
    assign ram_we    = (cmd.op == OP_PAY) && pos_reg[0] && (pos_reg != POS_W'(1));

    lsd_ram #(
        .WIDTH (DIST_W),
        .DEPTH (CABINS),
        .AW    (AW)
    ) u_cabin_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({in_byte_reg, pending_reg}),
        .re    (cmd.drain_rd),
        .raddr (drain_idx_reg),
        .rdata (ram_rdata)
    );

    // Status to the controller
    assign target = (pps_reg == 8'd0) ? 8'd1 : pps_reg;

    always_comb begin
        stat.in_valid      = in_valid_reg;
        stat.in_cmd        = in_cmd_reg;
        stat.out_free      = !out_valid_reg || m_tready;
        stat.scan_mode     = scan_mode_reg;
        stat.std_full      = (std_pos_reg == 3'd4);
        stat.std_start     = rec_reg[0][0] && !rec_reg[0][1];
        stat.std_check     = rec_reg[1][0];
        stat.frame_started = frame_started_reg;
        stat.cnt_gt1       = (count_reg > COUNT_W'(1));
        stat.sync1_ok      = (in_byte_reg[7:4] == SYNC1_NIB);
        stat.sync2_ok      = (in_byte_reg[7:4] == SYNC2_NIB);
        stat.pay_final     = (pos_reg == POS_W'(PAY_TOTAL - 1));
        stat.xor_match     = ((xor_reg ^ in_byte_reg) == exp_reg);
        stat.drain_last    = (drain_idx_reg == AW'(CABINS - 1));
        stat.target_hit    = (count_reg >= {8'h00, target});
    end

    // Output register: load a result, drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_ev_reg   <= cmd.out_sel;
            out_last_reg <= cmd.out_last;
            out_cnt_reg  <= count_next;
            case (cmd.out_sel)
                EV_POINT: begin
                    out_q_reg    <= rec_reg[0];
                    out_ang_reg  <= {rec_reg[2], rec_reg[1][7:1]};
                    out_dist_reg <= {in_byte_reg, rec_reg[3]};
                    out_idx_reg  <= '0;
                end
                EV_CABIN: begin
                    out_q_reg    <= '0;
                    out_ang_reg  <= angle_reg;
                    out_dist_reg <= ram_rdata;
                    out_idx_reg  <= IDX_W'(drain_idx_reg);
                end
                default: begin
                    out_q_reg    <= '0;
                    out_ang_reg  <= '0;
                    out_dist_reg <= '0;
                    out_idx_reg  <= '0;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_ev_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {3'b000, out_cnt_reg, out_idx_reg, out_dist_reg, out_ang_reg, out_q_reg};

endmodule

`default_nettype wire

@@ rtl/lsd_ctrl.sv @@
// Controller of the lidar scan deframer: scan phase state machine that
// sequences the datapath. Depends on lsd_pkg.
`default_nettype none

module lsd_ctrl
    import lsd_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        can_take;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Consume a word only when a result it may cause has somewhere to go
    assign can_take = stat.in_valid && stat.out_free;

    // Next state and datapath commands
    always_comb begin
        state_next      = state_reg;
        cmd.op          = OP_NONE;
        cmd.cnt_inc     = 1'b0;
        cmd.out_load    = 1'b0;
        cmd.out_sel     = EV_POINT;
        cmd.out_last    = 1'b0;
        cmd.drain_start = 1'b0;
        cmd.drain_rd    = 1'b0;
        cmd.drain_next  = 1'b0;

        case (state_reg)
            ST_IDLE, ST_STD, ST_SYNC1, ST_SYNC2, ST_PAYLOAD: begin
                if (can_take) begin
                    if (stat.in_cmd == CMD_ARM) begin
                        // Abandon any scan and start afresh in the set mode
                        cmd.op     = OP_ARM;
                        state_next = (stat.scan_mode == MODE_EXPRESS) ? ST_SYNC1 : ST_STD;
                    end else begin
                        case (state_reg)
                            ST_STD: begin
                                cmd.op = OP_STD;
                                if (stat.std_full) begin
                                    if (stat.std_start && !stat.frame_started) begin
                                        cmd.op = OP_STD;
                                    end else if (stat.frame_started && stat.std_start
                                                 && stat.cnt_gt1) begin
                                        if (stat.std_check) begin
                                            cmd.out_load = 1'b1;
                                            cmd.out_sel  = EV_DONE;
                                            cmd.out_last = 1'b1;
                                            state_next   = ST_IDLE;
                                        end
                                    end else if (stat.frame_started) begin
                                        cmd.cnt_inc  = 1'b1;
                                        cmd.out_load = 1'b1;
                                        cmd.out_sel  = EV_POINT;
                                        cmd.out_last = 1'b1;
                                    end
                                end
                            end
                            ST_SYNC1: begin
                                cmd.op = OP_SYNC1;
                                if (stat.sync1_ok) begin
                                    state_next = ST_SYNC2;
                                end
                            end
                            ST_SYNC2: begin
                                cmd.op     = OP_SYNC2;
                                state_next = stat.sync2_ok ? ST_PAYLOAD : ST_SYNC1;
                            end
                            ST_PAYLOAD: begin
                                cmd.op = OP_PAY;
                                if (stat.pay_final) begin
                                    if (!stat.xor_match) begin
                                        cmd.out_load = 1'b1;
                                        cmd.out_sel  = EV_ERROR;
                                        cmd.out_last = 1'b1;
                                        state_next   = ST_IDLE;
                                    end else begin
                                        cmd.cnt_inc     = 1'b1;
                                        cmd.drain_start = 1'b1;
                                        state_next      = ST_DRAIN_RD;
                                    end
                                end
                            end
                            default: begin
                                // Data while idle is dropped
                                cmd.op = OP_DROP;
                            end
                        endcase
                    end
                end
            end
            ST_DRAIN_RD: begin
                cmd.drain_rd = 1'b1;
                state_next   = ST_DRAIN_OUT;
            end
            ST_DRAIN_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = EV_CABIN;
                    cmd.out_last = stat.drain_last && !stat.target_hit;
                    if (stat.drain_last) begin
                        state_next = stat.target_hit ? ST_DONE_OUT : ST_SYNC1;
                    end else begin
                        cmd.drain_next = 1'b1;
                        state_next     = ST_DRAIN_RD;
                    end
                end
            end
            ST_DONE_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = EV_DONE;
                    cmd.out_last = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/lidar_scan_deframer.sv @@
// Lidar scan deframer, top level: joins the controller and the datapath.
// Depends on lsd_pkg, lsd_ctrl, lsd_dp (and lsd_ram below it).
//
// Usage:
//   s_ channel carries one word per received event: s_tuser 0 arms a new
//   scan (mode taken from scan_mode), s_tuser 1 carries a data byte in
//   s_tdata. m_ channel carries results; m_tuser gives the kind (point,
//   cabin, done, error), m_tlast marks the final result of an input word.
//   The cfg_ channel writes scan_mode (index 0) and packets_per_scan
//   (index 1); it is always ready and should be used while the block idles.
//   A word enters the hold stage and its result, if any, is then loaded
//   into the output register that drives m_tvalid; the load waits while
//   the output register is full and not taken. A sustained rate of one word
//   per cycle holds while the receiver keeps m_tready high and no drain runs.
//   A good express packet drains its CABINS_PER_PACKET cabins from the
//   cabin RAM, each by a read and then an output load, plus a done result
//   once the packet target is hit; input words wait in the hold stage.
//   When the receiver stalls the output register holds, one more input
//   word is taken into the hold stage, then s_tready drops.
//   Reset clears all scan state and returns to idle at once; there is no
//   clearing pass. The cabin RAM needs no reset.
`default_nettype none

module lidar_scan_deframer
    import lsd_pkg::*;
#(
    parameter int CABINS_PER_PACKET = 40
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [BYTE_W-1:0]  s_tdata,   // [7:0] data_byte
    input  wire logic               s_tuser,   // [0] command
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // [7:0] quality, [22:8] angle_raw, [38:23] distance_raw,
    // [44:39] cabin_index, [60:45] count, [63:61] zero
    output logic [TDATA_W-1:0]      m_tdata,
    output logic [1:0]              m_tuser,   // [1:0] event_res
    output logic                    m_tlast,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_index,
    input  wire logic [7:0]         cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    lsd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .cmd     (cmd)
    );

    lsd_dp #(
        .CABINS (CABINS_PER_PACKET)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire

@@ verif/lidar_scan_deframer_tb.sv @@
// Testbench for lidar_scan_deframer: directed and random byte streams in both
// scan modes, checked word by word against a predictor held in the bench.
// Depends on lsd_pkg and the lidar_scan_deframer RTL.

module lidar_scan_deframer_tb;
    import lsd_pkg::*;

    localparam int   CABINS        = 40;
    localparam int   PAYLOAD_BYTES = 2 + 2 * CABINS;
    localparam int   SETTLE_CYCLES = 8;
    localparam logic MODE_STANDARD = 1'b0;

    // One result word as the block should emit it
    typedef struct packed {
        event_t       ev;
        logic [7:0]   quality;
        logic [14:0]  angle;
        logic [15:0]  distance;
        logic [5:0]   cabin;
        logic [15:0]  count;
        logic         last;
    } scan_result_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [BYTE_W-1:0]   s_tdata   = '0;
    logic                s_tuser   = 1'b0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic [1:0]          m_tuser;
    logic                m_tlast;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_index = 1'b0;
    logic [7:0]          cfg_data  = '0;

    scan_result_t expected_results[$];
    int           err_count  = 0;
    int           data_words = 0;
    bit           tx_burst   = 1'b0;
    bit           rx_burst   = 1'b0;

    // Predicted deframer state and registers
    logic         pr_mode    = MODE_STANDARD;
    logic [7:0]   pr_pps     = PPS_RESET;
    ctrl_state_t  pr_phase   = ST_IDLE;
    logic [6:0]   pr_pos     = '0;
    logic         pr_framed  = 1'b0;
    logic [31:0]  pr_record  = '0;
    logic [7:0]   pr_low     = '0;
    logic [7:0]   pr_sum_exp = '0;
    logic [7:0]   pr_xor     = '0;
    logic [15:0]  pr_angle   = '0;
    logic [15:0]  pr_cabins [CABINS];
    logic [15:0]  pr_count   = '0;

    lidar_scan_deframer #(
        .CABINS_PER_PACKET(CABINS)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Any byte value
    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Queue one expected result word
    task automatic note_result(input event_t ev, input logic [7:0] q, input logic [14:0] ang,
                               input logic [15:0] range_word, input logic [5:0] idx,
                               input logic [15:0] cnt, input logic last);
        scan_result_t r;
        r.ev       = ev;
        r.quality  = q;
        r.angle    = ang;
        r.distance = range_word;
        r.cabin    = idx;
        r.count    = cnt;
        r.last     = last;
        expected_results.insert(expected_results.size(), r);
    endtask

    // Saturate at the top of the counter
    task automatic bump_count;
        if (pr_count != COUNT_MAX)
            pr_count = pr_count + 16'd1;
    endtask

    // Advance the predicted deframer by one accepted input word
    task automatic deframe_word(input logic cmd, input logic [7:0] b);
        logic [7:0]  q, alo, ahi, dlo;
        logic        start_rec, check;
        logic [6:0]  pos;
        logic [15:0] target;
        int          i;
        if (cmd == CMD_ARM) begin
            pr_pos     = '0;
            pr_framed  = 1'b0;
            pr_record  = '0;
            pr_low     = '0;
            pr_sum_exp = '0;
            pr_xor     = '0;
            pr_angle   = '0;
            pr_count   = '0;
            for (i = 0; i < CABINS; i++)
                pr_cabins[i] = '0;
            pr_phase = (pr_mode == MODE_EXPRESS) ? ST_SYNC1 : ST_STD;
            return;
        end
        case (pr_phase)
            ST_STD: begin
                if (pr_pos < 4) begin
                    pr_record = pr_record | (32'(b) << (8 * pr_pos));
                    pr_pos    = pr_pos + 7'd1;
                end else begin
                    {dlo, ahi, alo, q} = pr_record;
                    pr_pos    = '0;
                    pr_record = '0;
                    start_rec = q[0] & ~q[1];
                    check     = alo[0];
                    if (start_rec && !pr_framed) begin
                        // drop records until a checked start record opens the frame
                        if (check)
                            pr_framed = 1'b1;
                    end else if (pr_framed && start_rec && pr_count > 1) begin
                        if (check) begin
                            note_result(EV_DONE, '0, '0, '0, '0, pr_count, 1'b1);
                            pr_phase = ST_IDLE;
                        end
                    end else if (pr_framed) begin
                        bump_count();
                        note_result(EV_POINT, q, {ahi, alo[7:1]}, {b, dlo}, '0, pr_count, 1'b1);
                    end
                end
            end
            ST_SYNC1: begin
                if (b[7:4] == SYNC1_NIB) begin
                    pr_sum_exp = {4'h0, b[3:0]};
                    pr_phase   = ST_SYNC2;
                end
            end
            ST_SYNC2: begin
                // a wrong second sync byte is consumed and the hunt restarts
                if (b[7:4] == SYNC2_NIB) begin
                    pr_sum_exp = {b[3:0], pr_sum_exp[3:0]};
                    pr_xor     = '0;
                    pr_pos     = '0;
                    pr_angle   = '0;
                    pr_phase   = ST_PAYLOAD;
                end else begin
                    pr_phase = ST_SYNC1;
                end
            end
            ST_PAYLOAD: begin
                pos    = pr_pos;
                pr_xor = pr_xor ^ b;
                if (pos == 0)
                    pr_angle = {8'h00, b};
                else if (pos == 1)
                    pr_angle[15:8] = b;
                else if (!pos[0])
                    pr_low = b;
                else
                    pr_cabins[(pos - 7'd2) >> 1] = {b, pr_low};
                pr_pos = pos + 7'd1;
                if (pr_pos == PAYLOAD_BYTES) begin
                    pr_pos = '0;
                    if (pr_xor != pr_sum_exp) begin
                        note_result(EV_ERROR, '0, '0, '0, '0, pr_count, 1'b1);
                        pr_phase = ST_IDLE;
                    end else begin
                        bump_count();
                        target = (pr_pps == 0) ? 16'd1 : {8'h00, pr_pps};
                        for (i = 0; i < CABINS; i++)
                            note_result(EV_CABIN, '0, pr_angle[14:0], pr_cabins[i], i[5:0],
                                        pr_count, (i == CABINS - 1) && (pr_count < target));
                        if (pr_count >= target) begin
                            note_result(EV_DONE, '0, '0, '0, '0, pr_count, 1'b1);
                            pr_phase = ST_IDLE;
                        end else begin
                            pr_phase = ST_SYNC1;
                        end
                    end
                end
            end
            default: ;  // idle: ignore data words
        endcase
    endtask

    // Send one input word after a random gap, then predict its results
    task automatic send_word(input logic cmd, input logic [7:0] b);
        int   gap;
        logic ready_seen;
        gap = tx_burst ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= b;
        // sample ready mid-cycle, clear of the edge that takes the word
        ready_seen = 1'b0;
        while (!ready_seen) begin
            @(negedge aclk);
            ready_seen = s_tready;
            @(posedge aclk);
        end
        if (cmd == CMD_DATA)
            data_words++;
        deframe_word(cmd, b);
    endtask

    task automatic send_record(input logic [7:0] q, input logic [7:0] alo, input logic [7:0] ahi,
                               input logic [7:0] dlo, input logic [7:0] dhi);
        send_word(CMD_DATA, q);
        send_word(CMD_DATA, alo);
        send_word(CMD_DATA, ahi);
        send_word(CMD_DATA, dlo);
        send_word(CMD_DATA, dhi);
    endtask

    // Cabin words are (random & keep) | setbits; corrupt flips one checksum bit
    task automatic send_packet(input logic [15:0] start_angle, input logic [15:0] keep,
                               input logic [15:0] setbits, input bit corrupt);
        logic [7:0]  payload [PAYLOAD_BYTES];
        logic [7:0]  sum;
        logic [15:0] cab;
        int          i;
        payload[0] = start_angle[7:0];
        payload[1] = start_angle[15:8];
        for (i = 0; i < CABINS; i++) begin
            cab                = (16'($urandom_range(0, 65535)) & keep) | setbits;
            payload[2 + 2 * i] = cab[7:0];
            payload[3 + 2 * i] = cab[15:8];
        end
        sum = '0;
        for (i = 0; i < PAYLOAD_BYTES; i++)
            sum = sum ^ payload[i];
        if (corrupt)
            sum = sum ^ (8'h01 << $urandom_range(0, 7));
        send_word(CMD_DATA, {SYNC1_NIB, sum[3:0]});
        send_word(CMD_DATA, {SYNC2_NIB, sum[7:4]});
        for (i = 0; i < PAYLOAD_BYTES; i++)
            send_word(CMD_DATA, payload[i]);
    endtask

    // Any quality byte that is not a start record
    function automatic logic [7:0] random_quality();
        logic [7:0] q;
        q = rand_byte();
        if (q[1:0] == 2'b01)
            q[1] = 1'b1;
        return q;
    endfunction

    task automatic write_reg(input logic idx, input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_SCAN_MODE)
            pr_mode = v[0];
        else
            pr_pps = v;
    endtask

    task automatic configure(input logic mode, input logic [7:0] pps);
        write_reg(REG_SCAN_MODE, {7'd0, mode});
        write_reg(REG_PACKETS, pps);
        cfg_valid <= 1'b0;
    endtask

    // Hold the input and wait until every predicted word has come out
    task automatic wait_idle;
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic test_standard_scan;
        wait_idle();
        configure(MODE_STANDARD, PPS_RESET);
        send_word(CMD_DATA, 8'hA5);                        // ignored while idle
        send_word(CMD_ARM, 8'h00);
        send_record(8'h01, 8'h00, 8'h00, 8'h00, 8'h00);    // start without check, dropped
        send_record(8'h01, 8'h01, 8'h00, 8'h00, 8'h00);    // frame start
        send_record(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);    // point at the field maxima
        send_record(8'h01, 8'h00, 8'h00, 8'h00, 8'h00);    // unchecked start, one point: kept
        send_record(8'hFD, 8'hFE, 8'h80, 8'h00, 8'h00);    // unchecked start, two points: dropped
        send_record(8'h01, 8'h01, 8'h00, 8'h00, 8'h00);    // done
    endtask

    task automatic test_express_sync;
        wait_idle();
        configure(MODE_EXPRESS, 8'd0);                     // zero packets count as one
        send_word(CMD_ARM, 8'hFF);
        send_word(CMD_DATA, 8'h5F);                        // not a sync byte
        send_word(CMD_DATA, 8'hA3);
        send_word(CMD_DATA, 8'h12);                        // broken second sync
        send_packet(16'hFFFF, 16'h0000, 16'hFFFF, 1'b0);   // all ones, then done
        send_word(CMD_DATA, 8'hA0);                        // ignored after done
        send_word(CMD_ARM, 8'h00);
        send_packet(16'h0000, 16'h0000, 16'h0000, 1'b1);   // checksum error
    endtask

    task automatic test_mode_change_mid_scan;
        wait_idle();
        configure(MODE_EXPRESS, 8'd255);
        send_word(CMD_ARM, 8'h00);
        // mode change lands only at the next arm
        wait_idle();
        configure(MODE_STANDARD, 8'd255);
        send_packet(16'($urandom_range(0, 65535)), 16'hFFFF, 16'h0000, 1'b0);
        // arm during the scan: restarts in standard mode
        send_word(CMD_ARM, 8'hFF);
        send_record(8'h01, 8'h03, 8'h12, 8'h34, 8'h56);
        send_record(random_quality(), rand_byte(), rand_byte(), rand_byte(), rand_byte());
    endtask

    task automatic test_random_records;
        int         first, n, r;
        logic [7:0] q, alo;
        first = data_words;
        wait_idle();
        configure(MODE_STANDARD, rand_byte());
        while (data_words - first < 24) begin
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            send_word(CMD_ARM, rand_byte());
            // knock the record boundary out of step now and then
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 4)) send_word(CMD_DATA, rand_byte());
            if ($urandom_range(0, 2) == 0)
                send_record(random_quality(), rand_byte(), rand_byte(), rand_byte(),
                            rand_byte());
            q = rand_byte();
            q[1:0] = 2'b01;
            alo = rand_byte();
            alo[0] = 1'b1;
            send_record(q, alo, rand_byte(), rand_byte(), rand_byte());
            n = $urandom_range(0, 10);
            for (r = 0; r < n; r++) begin
                case ($urandom_range(0, 11))
                    0: begin
                        q = rand_byte();
                        q[1:0] = 2'b01;
                        alo = rand_byte();
                        alo[0] = 1'b0;
                        send_record(q, alo, rand_byte(), rand_byte(), rand_byte());
                    end
                    1: send_word(CMD_ARM, rand_byte());
                    default: send_record(random_quality(), rand_byte(), rand_byte(),
                                         rand_byte(), rand_byte());
                endcase
            end
            // close the scan most of the time; otherwise the next arm abandons it
            if ($urandom_range(0, 4) != 0) begin
                q = rand_byte();
                q[1:0] = 2'b01;
                alo = rand_byte();
                alo[0] = 1'b1;
                send_record(q, alo, rand_byte(), rand_byte(), rand_byte());
            end
        end
    endtask

    task automatic test_random_packets;
        int          first, npk, k;
        logic [7:0]  b, pps;
        logic [15:0] keep, setbits;
        first = data_words;
        while (data_words - first < 60) begin
            wait_idle();
            case ($urandom_range(0, 7))
                0:       pps = 8'd0;
                1:       pps = 8'd255;
                default: pps = 8'($urandom_range(1, 3));
            endcase
            configure(MODE_EXPRESS, pps);
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            send_word(CMD_ARM, rand_byte());
            // line noise ahead of the first sync byte
            repeat ($urandom_range(0, 3)) begin
                b = rand_byte();
                if (b[7:4] == SYNC1_NIB)
                    b[7:4] = 4'h0;
                send_word(CMD_DATA, b);
            end
            if ($urandom_range(0, 3) == 0) begin
                b = rand_byte();
                b[7:4] = SYNC1_NIB;
                send_word(CMD_DATA, b);
                b = rand_byte();
                if (b[7:4] == SYNC2_NIB)
                    b[7:4] = 4'hF;
                send_word(CMD_DATA, b);
            end
            npk = $urandom_range(1, 2);
            for (k = 0; k < npk && pr_phase != ST_IDLE; k++) begin
                case ($urandom_range(0, 9))
                    0:       begin keep = 16'h0000; setbits = 16'h0000; end
                    1:       begin keep = 16'h0000; setbits = 16'hFFFF; end
                    default: begin keep = 16'hFFFF; setbits = 16'h0000; end
                endcase
                send_packet(16'($urandom_range(0, 65535)), keep, setbits,
                            $urandom_range(0, 6) == 0);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    // Stall the result side at random and check every result word
    initial begin : result_checker
        int           stall;
        scan_result_t want, got;
        wait (aresetn === 1'b1);
        forever begin
            stall = rx_burst ? 0 : $urandom_range(0, 10);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            // sample mid-cycle; the word is taken at the following edge
            do @(negedge aclk); while (m_tvalid !== 1'b1);
            got.ev       = event_t'(m_tuser);
            got.quality  = m_tdata[7:0];
            got.angle    = m_tdata[22:8];
            got.distance = m_tdata[38:23];
            got.cabin    = m_tdata[44:39];
            got.count    = m_tdata[60:45];
            got.last     = m_tlast;
            @(posedge aclk);
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual kind %0d count %0h",
                         $time, got.ev, got.count);
                err_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("event_res", 32'(want.ev), 32'(got.ev));
                check_field("quality", 32'(want.quality), 32'(got.quality));
                check_field("angle_raw", 32'(want.angle), 32'(got.angle));
                check_field("distance_raw", 32'(want.distance), 32'(got.distance));
                check_field("cabin_index", 32'(want.cabin), 32'(got.cabin));
                check_field("count", 32'(want.count), 32'(got.count));
                check_field("last", 32'(want.last), 32'(got.last));
            end
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_standard_scan();
        test_express_sync();
        test_mode_change_mid_scan();
        test_random_records();
        test_random_packets();
        wait_idle();
        repeat (20) @(posedge aclk);
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Hard stop if the stream hangs
    initial begin
        #400_000;
        $display("FAILURE");
        $finish;
    end

endmodule
